@@ design/rpi_pkg.sv @@
// Shared constants, types and helpers for the ray/panel intersection unit.
`default_nettype none

package rpi_pkg;

  localparam int CoordBits   = 21;
  localparam int FracBits    = 12;
  localparam int DiffBits    = CoordBits + 1;
  localparam int PrBits      = DiffBits + CoordBits;
  localparam int RBits       = PrBits + 2;
  localparam int SBits       = 2 * CoordBits + 2;
  localparam int NumBits     = RBits + FracBits;
  localparam int QBits       = 32;
  localparam int DistBits    = 32;
  localparam int ProdBits    = CoordBits + DistBits;
  localparam int CrossBits   = 2 * DiffBits + 1;
  localparam int TnBits      = CrossBits + CoordBits;
  localparam int TnSumBits   = TnBits + 2;
  localparam int SmallBits   = 16;
  localparam int SqSumBits   = 2 * SmallBits + 2;
  localparam int RegBits     = 3 * CoordBits;
  localparam int LimitBits   = 32;
  localparam int CfgAddrBits = 3;
  localparam int CfgDataBits = 64;
  localparam int InDataBits  = 128;
  localparam int OutDataBits = 104;
  localparam int NumEdges    = 4;

  localparam logic [DistBits-1:0] ParallelDist = DistBits'(10000 << FracBits);
  localparam logic [DistBits-1:0] DistMax      = {1'b0, {(DistBits-1){1'b1}}};
  localparam logic [DistBits-1:0] DistMin      = {1'b1, {(DistBits-1){1'b0}}};

  typedef enum logic [CfgAddrBits-1:0] {
    RegCornerLa  = 3'd0,
    RegCornerLb  = 3'd1,
    RegCornerTa  = 3'd2,
    RegCornerTb  = 3'd3,
    RegColloc    = 3'd4,
    RegNormal    = 3'd5,
    RegDegLimit  = 3'd6
  } reg_idx_e;

  typedef logic [2:0][CoordBits-1:0] vec_t;

  typedef struct packed {
    vec_t a;
    vec_t u;
    logic neg;
    logic par;
  } div_side_t;

  function automatic logic signed [CoordBits-1:0] coord_sel(input logic [RegBits-1:0] r,
                                                            input int k);
    return r[k*CoordBits +: CoordBits];
  endfunction

endpackage

`default_nettype wire

@@ design/rpi_div.sv @@
// Pipelined restoring divider: an input stage, then one quotient bit per stage, with overflow detect.
`default_nettype none

module rpi_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [rpi_pkg::NumBits-1:0] in_num_i,
  input  wire logic [rpi_pkg::SBits-1:0]   in_den_i,
  input  wire rpi_pkg::div_side_t          in_side_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [rpi_pkg::QBits-1:0]        out_quot_o,
  output logic                             out_ovf_o,
  output rpi_pkg::div_side_t               out_side_o
);
  import rpi_pkg::*;

  localparam int Stages  = QBits + 1;
  localparam int ExtBits = SBits + QBits + 1;

  typedef struct packed {
    logic [NumBits-1:0] rem;
    logic [SBits-1:0]   den;
    logic [QBits-1:0]   quot;
    logic               ovf;
    div_side_t          side;
  } div_st_t;

  div_st_t            st_q [Stages];
  div_st_t            st_d [Stages];
  logic [Stages-1:0]  vld_q;
  logic [Stages:0]    rdy;

  always_comb begin
    rdy[Stages] = out_ready_i;
    for (int j = Stages - 1; j >= 0; j--) begin
      rdy[j] = !vld_q[j] || rdy[j+1];
    end
  end

  always_comb begin
    logic [ExtBits-1:0] rem_x;
    logic [ExtBits-1:0] den_x;
    st_d[0].rem  = in_num_i;
    st_d[0].den  = in_den_i;
    st_d[0].quot = '0;
    st_d[0].ovf  = 1'b0;
    st_d[0].side = in_side_i;
    for (int j = 1; j < Stages; j++) begin
      st_d[j] = st_q[j-1];
      rem_x   = ExtBits'(st_q[j-1].rem);
      den_x   = ExtBits'(st_q[j-1].den) << (QBits - j);
      // quotient must fit in QBits, else it saturates downstream
      if (j == 1) begin
        st_d[j].ovf = rem_x >= (ExtBits'(st_q[j-1].den) << QBits);
      end
      if (rem_x >= den_x) begin
        st_d[j].rem              = NumBits'(rem_x - den_x);
        st_d[j].quot[QBits - j]  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int j = 0; j < Stages; j++) begin
        if (rdy[j]) begin
          vld_q[j] <= (j == 0) ? in_valid_i : vld_q[j-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < Stages; j++) begin
      if (rdy[j]) begin
        st_q[j] <= st_d[j];
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[Stages-1];
  assign out_quot_o  = st_q[Stages-1].quot;
  assign out_ovf_o   = st_q[Stages-1].ovf;
  assign out_side_o  = st_q[Stages-1].side;

endmodule

`default_nettype wire

@@ design/ray_panel_intersection_unit.sv @@
// Ray against quadrilateral panel intersection unit, fully pipelined.
//
// Rays enter on the s_axis channel, one beat per ray (origin and direction,
// signed Q8.12). Each ray gives one result beat on m_axis: hit flag, plane
// point, ray distance (Q19.12) and parallel flag. The panel (four corners,
// collocation point, normal, degenerate limit) is written on the cfg port,
// which is always ready; write it only while no ray is in flight.
// Throughput: one ray per cycle while m_axis_tready is high. A ray passes 4
// front stages (input, products, sums, magnitudes), the 33-stage divider (an
// input stage, then one quotient bit per stage) and 7 back stages (saturate,
// scale multiply, point add, cross terms, crosses, dot terms, edge test).
// Each stage has its own valid bit and advances when the stage after it is
// empty or moving, so bubbles close up and a stalled receiver holds the
// result while stages behind it keep filling; s_axis_tready drops only once
// every stage is occupied. Reset clears all valid bits and loads the panel
// registers with zeros and a degenerate limit of one.
`default_nettype none

module ray_panel_intersection_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [rpi_pkg::CfgAddrBits-1:0] cfg_addr_i,
  input  wire logic [rpi_pkg::CfgDataBits-1:0] cfg_data_i,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (21 bits each), zero pad
  input  wire logic [rpi_pkg::InDataBits-1:0]  s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // hit, point_x, point_y, point_z (21 each), ray_distance (32), parallel, pad
  output logic [rpi_pkg::OutDataBits-1:0]      m_axis_tdata
);
  import rpi_pkg::*;

  // panel registers
  logic [RegBits-1:0]   la_q, lb_q, ta_q, tb_q, col_q, nrm_q;
  logic [LimitBits-1:0] lim_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      la_q  <= '0;
      lb_q  <= '0;
      ta_q  <= '0;
      tb_q  <= '0;
      col_q <= '0;
      nrm_q <= '0;
      lim_q <= LimitBits'(1);
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        RegCornerLa: la_q  <= cfg_data_i[RegBits-1:0];
        RegCornerLb: lb_q  <= cfg_data_i[RegBits-1:0];
        RegCornerTa: ta_q  <= cfg_data_i[RegBits-1:0];
        RegCornerTb: tb_q  <= cfg_data_i[RegBits-1:0];
        RegColloc:   col_q <= cfg_data_i[RegBits-1:0];
        RegNormal:   nrm_q <= cfg_data_i[RegBits-1:0];
        RegDegLimit: lim_q <= cfg_data_i[LimitBits-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- front stages ----------------
  typedef struct packed { vec_t a; vec_t u; } f0_t;
  typedef struct packed {
    vec_t a; vec_t u;
    logic [2:0][PrBits-1:0] pr;
    logic [2:0][PrBits-1:0] ps;
  } f1_t;
  typedef struct packed {
    vec_t a; vec_t u;
    logic [RBits-1:0] r;
    logic [SBits-1:0] s;
  } f2_t;
  typedef struct packed {
    logic [NumBits-1:0] num;
    logic [SBits-1:0]   den;
    div_side_t          side;
  } f3_t;

  f0_t f0_q, f0_d;
  f1_t f1_q, f1_d;
  f2_t f2_q, f2_d;
  f3_t f3_q, f3_d;
  logic [3:0] vf_q;
  logic [4:0] rdyf;
  logic       div_in_ready;

  always_comb begin
    rdyf[4] = div_in_ready;
    for (int k = 3; k >= 0; k--) begin
      rdyf[k] = !vf_q[k] || rdyf[k+1];
    end
  end
  assign s_axis_tready = rdyf[0];

  always_comb begin
    logic signed [DiffBits-1:0] cd;
    logic signed [RBits-1:0]    r_s;
    logic signed [SBits-1:0]    s_s;
    for (int k = 0; k < 3; k++) begin
      f0_d.a[k] = s_axis_tdata[k*CoordBits +: CoordBits];
      f0_d.u[k] = s_axis_tdata[(k+3)*CoordBits +: CoordBits];
    end
    f1_d.a = f0_q.a;
    f1_d.u = f0_q.u;
    for (int k = 0; k < 3; k++) begin
      cd = DiffBits'(coord_sel(col_q, k)) - DiffBits'($signed(f0_q.a[k]));
      f1_d.pr[k] = PrBits'(PrBits'(cd) * PrBits'(coord_sel(nrm_q, k)));
      f1_d.ps[k] = PrBits'(PrBits'($signed(f0_q.u[k])) * PrBits'(coord_sel(nrm_q, k)));
    end
    f2_d.a = f1_q.a;
    f2_d.u = f1_q.u;
    f2_d.r = RBits'($signed(f1_q.pr[0])) + RBits'($signed(f1_q.pr[1]))
           + RBits'($signed(f1_q.pr[2]));
    f2_d.s = SBits'($signed(f1_q.ps[0])) + SBits'($signed(f1_q.ps[1]))
           + SBits'($signed(f1_q.ps[2]));
    r_s = $signed(f2_q.r);
    s_s = $signed(f2_q.s);
    f3_d.num = NumBits'(r_s[RBits-1] ? RBits'(-r_s) : f2_q.r) << FracBits;
    f3_d.den = s_s[SBits-1] ? SBits'(-s_s) : f2_q.s;
    f3_d.side.a   = f2_q.a;
    f3_d.side.u   = f2_q.u;
    f3_d.side.neg = r_s[RBits-1] ^ s_s[SBits-1];
    f3_d.side.par = (f2_q.s == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= '0;
    end else begin
      if (rdyf[0]) vf_q[0] <= s_axis_tvalid;
      if (rdyf[1]) vf_q[1] <= vf_q[0];
      if (rdyf[2]) vf_q[2] <= vf_q[1];
      if (rdyf[3]) vf_q[3] <= vf_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdyf[0]) f0_q <= f0_d;
    if (rdyf[1]) f1_q <= f1_d;
    if (rdyf[2]) f2_q <= f2_d;
    if (rdyf[3]) f3_q <= f3_d;
  end

  // ---------------- divider ----------------
  logic             div_out_valid;
  logic             div_out_ready;
  logic [QBits-1:0] div_quot;
  logic             div_ovf;
  div_side_t        div_side;

  rpi_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vf_q[3]),
    .in_ready_o  (div_in_ready),
    .in_num_i    (f3_q.num),
    .in_den_i    (f3_q.den),
    .in_side_i   (f3_q.side),
    .out_valid_o (div_out_valid),
    .out_ready_i (div_out_ready),
    .out_quot_o  (div_quot),
    .out_ovf_o   (div_ovf),
    .out_side_o  (div_side)
  );

  // ---------------- back stages ----------------
  typedef struct packed {
    vec_t a; vec_t u;
    logic [DistBits-1:0] rdist;
    logic par; logic sat;
  } b0_t;
  typedef struct packed {
    vec_t a;
    logic [2:0][ProdBits-1:0] prod;
    logic [DistBits-1:0] rdist;
    logic par; logic sat;
  } b1_t;
  typedef struct packed {
    vec_t p;
    logic [DistBits-1:0] rdist;
    logic par; logic sat;
  } b2_t;
  typedef struct packed {
    vec_t p;
    logic [NumEdges-1:0][5:0][2*DiffBits-1:0] pp;
    logic [DistBits-1:0] rdist;
    logic par; logic sat;
  } b3_t;
  typedef struct packed {
    vec_t p;
    logic [NumEdges-1:0][2:0][CrossBits-1:0] t;
    logic [DistBits-1:0] rdist;
    logic par; logic sat;
  } b4_t;
  typedef struct packed {
    vec_t p;
    logic [NumEdges-1:0][2:0][TnBits-1:0] tn;
    logic [NumEdges-1:0][2:0][2*SmallBits-1:0] sq;
    logic [NumEdges-1:0][2:0] small_t;
    logic [DistBits-1:0] rdist;
    logic par; logic sat;
  } b5_t;
  typedef struct packed {
    logic hit;
    vec_t p;
    logic [DistBits-1:0] rdist;
    logic par;
  } b6_t;

  b0_t b0_q, b0_d;
  b1_t b1_q, b1_d;
  b2_t b2_q, b2_d;
  b3_t b3_q, b3_d;
  b4_t b4_q, b4_d;
  b5_t b5_q, b5_d;
  b6_t b6_q, b6_d;
  logic [6:0] vb_q;
  logic [7:0] rdyb;

  always_comb begin
    rdyb[7] = m_axis_tready;
    for (int k = 6; k >= 0; k--) begin
      rdyb[k] = !vb_q[k] || rdyb[k+1];
    end
  end
  assign div_out_ready = rdyb[0];

  // edge k runs from e_start[k] to e_end[k]: TA->TB, TB->LB, LB->LA, LA->TA
  logic [RegBits-1:0] e_start [NumEdges];
  logic [RegBits-1:0] e_end   [NumEdges];
  always_comb begin
    e_start[0] = ta_q; e_end[0] = tb_q;
    e_start[1] = tb_q; e_end[1] = lb_q;
    e_start[2] = lb_q; e_end[2] = la_q;
    e_start[3] = la_q; e_end[3] = ta_q;
  end

  always_comb begin
    logic signed [ProdBits:0]          pr_r;
    logic signed [ProdBits:0]          off;
    logic signed [ProdBits:0]          sum;
    logic signed [2:0][DiffBits-1:0]   v;
    logic signed [2:0][DiffBits-1:0]   w;
    logic signed [CrossBits-1:0]       tc;
    logic [CrossBits-1:0]              tm;
    logic signed [TnSumBits-1:0]       tsum;
    logic [SqSumBits-1:0]              sqs;
    logic                              all_small;
    logic [NumEdges-1:0]               pass;

    // saturate the quotient into the distance
    b0_d.a   = div_side.a;
    b0_d.u   = div_side.u;
    b0_d.par = div_side.par;
    b0_d.sat = 1'b0;
    if (div_side.par) begin
      b0_d.rdist = ParallelDist;
    end else if (!div_side.neg) begin
      if (div_ovf || div_quot[QBits-1]) begin
        b0_d.rdist = DistMax;
        b0_d.sat   = 1'b1;
      end else begin
        b0_d.rdist = div_quot;
      end
    end else begin
      if (div_ovf || div_quot > DistMin) begin
        b0_d.rdist = DistMin;
        b0_d.sat   = 1'b1;
      end else begin
        b0_d.rdist = DistBits'(-div_quot);
      end
    end

    b1_d.a     = b0_q.a;
    b1_d.rdist = b0_q.rdist;
    b1_d.par   = b0_q.par;
    b1_d.sat   = b0_q.sat;
    for (int k = 0; k < 3; k++) begin
      b1_d.prod[k] = ProdBits'(ProdBits'($signed(b0_q.u[k])) *
                               ProdBits'($signed(b0_q.rdist)));
    end

    // P = A + U*dist / 2^F, truncated toward zero, then clamped
    b2_d.rdist = b1_q.rdist;
    b2_d.par   = b1_q.par;
    b2_d.sat   = b1_q.sat;
    for (int k = 0; k < 3; k++) begin
      pr_r = (ProdBits+1)'($signed(b1_q.prod[k]));
      if (pr_r < 0) pr_r = pr_r + (ProdBits+1)'((1 << FracBits) - 1);
      off = pr_r >>> FracBits;
      sum = off + (ProdBits+1)'($signed(b1_q.a[k]));
      if (sum > (ProdBits+1)'((1 << (CoordBits-1)) - 1)) begin
        b2_d.p[k] = {1'b0, {(CoordBits-1){1'b1}}};
        b2_d.sat  = 1'b1;
      end else if (sum < -(ProdBits+1)'(1 << (CoordBits-1))) begin
        b2_d.p[k] = {1'b1, {(CoordBits-1){1'b0}}};
        b2_d.sat  = 1'b1;
      end else begin
        b2_d.p[k] = sum[CoordBits-1:0];
      end
    end

    // cross product terms of edge vector and point offset
    b3_d.p     = b2_q.p;
    b3_d.rdist = b2_q.rdist;
    b3_d.par   = b2_q.par;
    b3_d.sat   = b2_q.sat;
    for (int e = 0; e < NumEdges; e++) begin
      for (int k = 0; k < 3; k++) begin
        v[k] = DiffBits'(coord_sel(e_end[e], k)) - DiffBits'(coord_sel(e_start[e], k));
        w[k] = DiffBits'($signed(b2_q.p[k])) - DiffBits'(coord_sel(e_start[e], k));
      end
      b3_d.pp[e][0] = (2*DiffBits)'((2*DiffBits)'($signed(v[1])) * (2*DiffBits)'($signed(w[2])));
      b3_d.pp[e][1] = (2*DiffBits)'((2*DiffBits)'($signed(v[2])) * (2*DiffBits)'($signed(w[1])));
      b3_d.pp[e][2] = (2*DiffBits)'((2*DiffBits)'($signed(v[2])) * (2*DiffBits)'($signed(w[0])));
      b3_d.pp[e][3] = (2*DiffBits)'((2*DiffBits)'($signed(v[0])) * (2*DiffBits)'($signed(w[2])));
      b3_d.pp[e][4] = (2*DiffBits)'((2*DiffBits)'($signed(v[0])) * (2*DiffBits)'($signed(w[1])));
      b3_d.pp[e][5] = (2*DiffBits)'((2*DiffBits)'($signed(v[1])) * (2*DiffBits)'($signed(w[0])));
    end

    b4_d.p     = b3_q.p;
    b4_d.rdist = b3_q.rdist;
    b4_d.par   = b3_q.par;
    b4_d.sat   = b3_q.sat;
    for (int e = 0; e < NumEdges; e++) begin
      for (int k = 0; k < 3; k++) begin
        b4_d.t[e][k] = CrossBits'($signed(b3_q.pp[e][2*k]))
                     - CrossBits'($signed(b3_q.pp[e][2*k+1]));
      end
    end

    b5_d.p     = b4_q.p;
    b5_d.rdist = b4_q.rdist;
    b5_d.par   = b4_q.par;
    b5_d.sat   = b4_q.sat;
    for (int e = 0; e < NumEdges; e++) begin
      for (int k = 0; k < 3; k++) begin
        tc = $signed(b4_q.t[e][k]);
        tm = tc[CrossBits-1] ? CrossBits'(-tc) : b4_q.t[e][k];
        b5_d.tn[e][k]      = TnBits'(TnBits'(tc) * TnBits'(coord_sel(nrm_q, k)));
        b5_d.small_t[e][k] = (tm[CrossBits-1:SmallBits] == '0);
        b5_d.sq[e][k]      = (2*SmallBits)'(tm[SmallBits-1:0]) *
                             (2*SmallBits)'(tm[SmallBits-1:0]);
      end
    end

    // edge passes when cross product is near zero or points along the normal
    for (int e = 0; e < NumEdges; e++) begin
      tsum = TnSumBits'($signed(b5_q.tn[e][0])) + TnSumBits'($signed(b5_q.tn[e][1]))
           + TnSumBits'($signed(b5_q.tn[e][2]));
      sqs  = SqSumBits'(b5_q.sq[e][0]) + SqSumBits'(b5_q.sq[e][1])
           + SqSumBits'(b5_q.sq[e][2]);
      all_small = &b5_q.small_t[e];
      pass[e]   = (all_small && sqs < SqSumBits'(lim_q)) || !tsum[TnSumBits-1];
    end
    b6_d.hit   = (&pass) && !b5_q.par && !b5_q.sat;
    b6_d.p     = b6_d.hit ? b5_q.p : '0;
    b6_d.rdist = b5_q.rdist;
    b6_d.par   = b5_q.par;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= '0;
    end else begin
      for (int k = 0; k < 7; k++) begin
        if (rdyb[k]) begin
          vb_q[k] <= (k == 0) ? div_out_valid : vb_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdyb[0]) b0_q <= b0_d;
    if (rdyb[1]) b1_q <= b1_d;
    if (rdyb[2]) b2_q <= b2_d;
    if (rdyb[3]) b3_q <= b3_d;
    if (rdyb[4]) b4_q <= b4_d;
    if (rdyb[5]) b5_q <= b5_d;
    if (rdyb[6]) b6_q <= b6_d;
  end

  assign m_axis_tvalid = vb_q[6];
  assign m_axis_tdata  = {7'b0, b6_q.par, b6_q.rdist, b6_q.p[2], b6_q.p[1], b6_q.p[0],
                          b6_q.hit};

  // ---------------- checks ----------------
  a_parallel_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[96] |-> !m_axis_tdata[0] &&
      m_axis_tdata[95:64] == ParallelDist)
    else $error("parallel ray reported a hit or wrong distance");

  a_miss_zero_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[63:1] == '0)
    else $error("miss with nonzero point");

  a_fill_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> vf_q[0] && !rdyf[1])
    else $error("input stalled with room in front stages");

endmodule

`default_nettype wire
